>>> hdl/rcsfd_pkg.sv
// ----------------------------------------------------------------------------
// rcsfd_pkg - shared types for the RC serial frame detector
// Beat structs, event codes, opcodes and register indexes.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

  localparam int FRAME_BYTES_DEF   = 5;
  localparam int CHANNEL_COUNT_DEF = 4;
  localparam int BYTE_W            = 8;
  localparam int TIMEOUT_W         = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int NUM_CHANS         = 4;

  localparam logic [BYTE_W-1:0]    SYNC_RESET    = 8'd239;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  // register indexes on the configuration port
  localparam logic REG_SYNC    = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result event codes
  localparam logic [1:0] EV_PRESENT = 2'd0;
  localparam logic [1:0] EV_FRAME   = 2'd1;
  localparam logic [1:0] EV_ABSENT  = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [BYTE_W-1:0] chan_a;
    logic [BYTE_W-1:0] chan_b;
    logic [BYTE_W-1:0] chan_c;
    logic [BYTE_W-1:0] chan_d;
  } out_beat_t;

endpackage

>>> hdl/rc_serial_frame_detector_unit.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_detector_unit - RC transmitter link frame detector
// Bit-reverses serial bytes, assembles sync-led frames, detects link
// presence and reports present / new frame / absent events.
// ----------------------------------------------------------------------------
// One input beat is taken every cycle while in_stall is low; the update for a
// byte or a tick is one step on the state registers. Results go through a
// two-deep output stage (output register plus skid register), so input keeps
// flowing while one result waits; in_stall rises only once both are full. Each
// beat gives at most one result, written to the output register or to the skid
// while that is held. Configuration writes take effect at the next clock edge.
module rc_serial_frame_detector_unit #(
  parameter int FRAME_BYTES   = rcsfd_pkg::FRAME_BYTES_DEF,
  parameter int CHANNEL_COUNT = rcsfd_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rcsfd_pkg::in_beat_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rcsfd_pkg::out_beat_t                out_data,
  input  logic                                cfg_we,
  input  logic                                cfg_idx,
  input  logic [rcsfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import rcsfd_pkg::*;

  localparam int FILL_W = $clog2(FRAME_BYTES);
  localparam int DC_W   = $clog2(2*FRAME_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(FRAME_BYTES - 1);
  localparam logic [DC_W-1:0]   DC_FRAME   = DC_W'(FRAME_BYTES);
  localparam logic [DC_W-1:0]   DC_PRESENT = DC_W'(2*FRAME_BYTES - 1);

  function automatic logic [BYTE_W-1:0] bit_rev(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

  // configuration
  logic [BYTE_W-1:0]    sync_r;
  logic [TIMEOUT_W-1:0] timeout_r;

  // link state
  logic                 in_det_r,  in_det_nxt;
  logic [DC_W-1:0]      dc_r,      dc_nxt;
  logic [FILL_W-1:0]    fill_r,    fill_nxt;
  logic                 armed_r,   armed_nxt;
  logic [TIMEOUT_W-1:0] ticks_r,   ticks_nxt;
  logic [BYTE_W-1:0]    store_r [FRAME_BYTES];

  // output staging
  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;
  out_beat_t skid_data_r, skid_data_nxt;

  logic              accept;
  logic              is_byte;
  logic              is_sync;
  logic [BYTE_W-1:0] rev_byte;

  // frame assembly step for the current byte
  logic              tk_write;
  logic [FILL_W-1:0] tk_idx;
  logic [FILL_W-1:0] tk_fill;
  logic              tk_done;

  logic              st_write;
  logic              res_v;
  logic [1:0]        res_kind;
  logic [BYTE_W-1:0] chan_v [NUM_CHANS];
  out_beat_t         res_data;

  assign accept   = in_valid && !in_stall;
  assign is_byte  = (in_data.opcode == OP_BYTE);
  assign is_sync  = (in_data.data_byte == sync_r);
  assign rev_byte = bit_rev(in_data.data_byte);

  always_comb begin
    tk_write = 1'b0;
    tk_idx   = fill_r;
    tk_fill  = fill_r;
    tk_done  = 1'b0;
    if (is_sync || fill_r != '0) begin
      tk_write = 1'b1;
      tk_idx   = is_sync ? '0 : fill_r;
      if (tk_idx == FILL_LAST) begin
        tk_fill = '0;
        tk_done = 1'b1;
      end else begin
        tk_fill = tk_idx + 1'b1;
      end
    end
  end

  always_comb begin
    in_det_nxt = in_det_r;
    dc_nxt     = dc_r;
    fill_nxt   = fill_r;
    armed_nxt  = armed_r;
    ticks_nxt  = ticks_r;
    st_write   = 1'b0;
    res_v      = 1'b0;
    res_kind   = EV_FRAME;
    if (accept) begin
      if (is_byte) begin
        if (in_det_r) begin
          armed_nxt = 1'b1;
          ticks_nxt = timeout_r;
          if (dc_r == '0) begin
            if (is_sync) begin
              dc_nxt   = DC_W'(1);
              st_write = tk_write;
              fill_nxt = tk_fill;
            end
          end else if (dc_r == DC_FRAME && !is_sync) begin
            // second frame did not follow at once: start over
            dc_nxt   = '0;
            fill_nxt = '0;
          end else begin
            dc_nxt   = dc_r + 1'b1;
            st_write = tk_write;
            fill_nxt = tk_fill;
            if (dc_r >= DC_PRESENT) begin
              in_det_nxt = 1'b0;
              res_v      = 1'b1;
              res_kind   = EV_PRESENT;
            end
          end
        end else begin
          st_write = tk_write;
          fill_nxt = tk_fill;
          if (tk_done) begin
            ticks_nxt = timeout_r;
            res_v     = 1'b1;
            res_kind  = EV_FRAME;
          end
        end
      end else if (armed_r) begin
        ticks_nxt = (ticks_r != '0) ? ticks_r - 1'b1 : '0;
        if (ticks_r <= TIMEOUT_W'(1)) begin
          in_det_nxt = 1'b1;
          dc_nxt     = '0;
          armed_nxt  = 1'b0;
          fill_nxt   = '0;
          res_v      = 1'b1;
          res_kind   = EV_ABSENT;
        end
      end
    end
  end

  // channel bytes, including the byte written by this beat
  for (genvar g = 0; g < NUM_CHANS; g++) begin : g_chan
    if (g < CHANNEL_COUNT && g + 1 < FRAME_BYTES) begin : g_live
      always_comb begin
        if (res_kind == EV_ABSENT) begin
          chan_v[g] = '0;
        end else if (st_write && tk_idx == FILL_W'(g + 1)) begin
          chan_v[g] = rev_byte;
        end else begin
          chan_v[g] = store_r[g + 1];
        end
      end
    end else begin : g_none
      assign chan_v[g] = '0;
    end
  end

  always_comb begin
    res_data.event_kind = res_kind;
    res_data.chan_a     = chan_v[0];
    res_data.chan_b     = chan_v[1];
    res_data.chan_c     = chan_v[2];
    res_data.chan_d     = chan_v[3];
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_v;
        skid_data_nxt  = res_data;
      end else begin
        out_valid_nxt  = res_v;
        out_data_nxt   = res_data;
      end
    end else if (res_v) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r    <= SYNC_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SYNC:    sync_r    <= cfg_wdata[BYTE_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_det_r     <= 1'b1;
      dc_r         <= '0;
      fill_r       <= '0;
      armed_r      <= 1'b0;
      ticks_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      in_det_r     <= in_det_nxt;
      dc_r         <= dc_nxt;
      fill_r       <= fill_nxt;
      armed_r      <= armed_nxt;
      ticks_r      <= ticks_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
    if (st_write) begin
      store_r[tk_idx] <= rev_byte;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/rcsfd_checker.sv
// ----------------------------------------------------------------------------
// rcsfd_checker - port-level checks for the frame detector
// Watches the top level's ports and flags misbehaviour over time.
// ----------------------------------------------------------------------------
module rcsfd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rcsfd_pkg::out_beat_t out_data
);

  import rcsfd_pkg::*;

  // a held result beat must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // absent events never carry channel bytes
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == EV_ABSENT |->
      out_data.chan_a == '0 && out_data.chan_b == '0 &&
      out_data.chan_c == '0 && out_data.chan_d == '0)
    else $error("absent event with channel data");

  // reset empties the output staging
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output staging not empty after reset");

  // input back-pressure only follows a result held downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

endmodule

bind rc_serial_frame_detector_unit rcsfd_checker u_rcsfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> sim/rc_serial_frame_detector_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_serial_frame_detector_unit_test - link event check for the frame detector
// Drives serial bytes and millisecond ticks with random gaps and result-side
// stalls, tracks link detection, frames and timeouts in a behavioural copy of
// the block, and compares every reported event field by field.
// ----------------------------------------------------------------------------
module rc_serial_frame_detector_unit_test;
  import rcsfd_pkg::*;

  class link_event_tracker;
    localparam int FB = FRAME_BYTES_DEF;

    logic [7:0]  sync_byte;
    logic [15:0] timeout_len;
    bit          detecting;
    int          det_count;
    int          fill;
    logic [7:0]  store [FB];
    bit          armed;
    logic [15:0] ticks_left;
    out_beat_t   expected_events[$];
    int          errors;

    function new();
      sync_byte   = SYNC_RESET;
      timeout_len = TIMEOUT_RESET;
      ticks_left  = '0;
      errors      = 0;
      foreach (store[i]) store[i] = '0;
      restart_detect();
    endfunction

    function void restart_detect();
      detecting = 1'b1;
      det_count = 0;
      armed     = 1'b0;
      fill      = 0;
    endfunction

    // true once the frame has just filled up
    function bit place_byte(logic [7:0] b);
      if (b == sync_byte) fill = 0;
      else if (fill == 0) return 1'b0;
      if (fill < FB) store[fill] = {<<{b}};
      fill++;
      if (fill >= FB) begin
        fill = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push_event(logic [1:0] kind, bit with_chans);
      out_beat_t ev;
      ev.event_kind = kind;
      ev.chan_a = with_chans ? store[1] : '0;
      ev.chan_b = with_chans ? store[2] : '0;
      ev.chan_c = with_chans ? store[3] : '0;
      ev.chan_d = with_chans ? store[4] : '0;
      expected_events.push_back(ev);
    endfunction

    function void note_beat(in_beat_t b);
      if (b.opcode == OP_BYTE) begin
        if (detecting) begin
          armed      = 1'b1;
          ticks_left = timeout_len;
          if (det_count == 0) begin
            if (b.data_byte == sync_byte) begin
              det_count = 1;
              fill      = 0;
              void'(place_byte(b.data_byte));
            end
          end else if (det_count == FB && b.data_byte != sync_byte) begin
            // second frame must follow the first directly
            det_count = 0;
            fill      = 0;
          end else begin
            det_count++;
            void'(place_byte(b.data_byte));
            if (det_count >= 2 * FB) begin
              detecting = 1'b0;
              push_event(EV_PRESENT, 1'b1);
            end
          end
        end else if (place_byte(b.data_byte)) begin
          ticks_left = timeout_len;
          push_event(EV_FRAME, 1'b1);
        end
      end else if (armed) begin
        if (ticks_left != 0) ticks_left--;
        if (ticks_left == 0) begin
          restart_detect();
          push_event(EV_ABSENT, 1'b0);
        end
      end
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_event(out_beat_t got);
      out_beat_t want;
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      cmp_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
      cmp_field("chan_a", want.chan_a, got.chan_a);
      cmp_field("chan_b", want.chan_b, got.chan_b);
      cmp_field("chan_c", want.chan_c, got.chan_c);
      cmp_field("chan_d", want.chan_d, got.chan_d);
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  out_beat_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_idx   = REG_SYNC;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  link_event_tracker tracker = new();
  int beats_sent = 0;
  bit tx_fast    = 1'b0;
  bit rx_fast    = 1'b0;
  int stall_left = 0;

  rc_serial_frame_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall after each accepted beat, with calm stretches
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_event(out_data);
      if ($urandom_range(0, 31) == 0) rx_fast = !rx_fast;
      stall_left = rx_fast ? 0 : $urandom_range(0, 12);
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input in_beat_t b);
    int gap;
    if (beats_sent % 40 == 0) tx_fast = ($urandom_range(0, 2) == 0);
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_beat(b);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [7:0] v);
    in_beat_t b;
    b.opcode    = OP_BYTE;
    b.data_byte = v;
    send_beat(b);
  endtask

  task automatic send_tick();
    in_beat_t b;
    b.opcode    = OP_TICK;
    b.data_byte = 8'($urandom);
    send_beat(b);
  endtask

  // mostly a proper channel byte, now and then a stray sync
  function automatic logic [7:0] pick_chan();
    logic [7:0] b;
    if ($urandom_range(0, 19) == 0) return tracker.sync_byte;
    do b = 8'($urandom); while (b == tracker.sync_byte);
    return b;
  endfunction

  task automatic send_frame(input int n_chans);
    int tmo;
    tmo = tracker.timeout_len;
    send_byte(tracker.sync_byte);
    for (int i = 0; i < n_chans; i++) begin
      // now and then one to three ticks between bytes, short of the timeout
      if (tmo > 1 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, tmo - 1 < 3 ? tmo - 1 : 3)) send_tick();
      send_byte(pick_chan());
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] sync_v, input logic [15:0] tmo_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SYNC;
    cfg_wdata <= {8'($urandom), sync_v};
    @(posedge clk);
    cfg_idx   <= REG_TIMEOUT;
    cfg_wdata <= tmo_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.sync_byte   = sync_v;
    tracker.timeout_len = tmo_v;
    @(posedge clk);
  endtask

  task automatic run_phase(input int n_beats);
    int stop;
    int pick;
    int tmo;
    stop = beats_sent + n_beats;
    tmo  = tracker.timeout_len;
    while (beats_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(4);
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 5)) send_tick();
      end else if (pick < 88) begin
        // run the timer out when that is affordable
        if (tmo <= 64) repeat (tmo + $urandom_range(0, 3)) send_tick();
        else repeat ($urandom_range(1, 5)) send_tick();
      end else begin
        send_frame($urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    #10_000_000;
    $display("rc_serial_frame_detector_unit test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tick while unarmed, stray byte, a clean pair of frames to go
    // present, a stray byte outside a frame, and a sync that restarts a frame
    send_tick();
    send_byte(8'h00);
    send_byte(SYNC_RESET);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(SYNC_RESET);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h12);
    send_byte(SYNC_RESET);
    send_byte(8'h7F);
    send_byte(SYNC_RESET);
    send_byte(8'hFE);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_tick();
    send_tick();

    run_phase(225);
    settle();
    write_config(8'h00, 16'd1);
    run_phase(225);
    settle();
    write_config(8'hFF, 16'hFFFF);
    run_phase(225);
    settle();
    // zero timeout: the first armed tick drops the link
    write_config(8'($urandom), 16'd0);
    run_phase(225);
    settle();
    write_config(8'($urandom), 16'($urandom_range(2, 40)));
    run_phase(225);
    settle();
    write_config(8'($urandom), 16'($urandom_range(2, 12)));
    run_phase(225);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("rc_serial_frame_detector_unit test passed");
    end else begin
      $display("rc_serial_frame_detector_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/rcsfd_pkg.sv
hdl/rc_serial_frame_detector_unit.sv
hdl/rcsfd_checker.sv
sim/rc_serial_frame_detector_unit_test.sv
